// ----- rtl/mwm_pkg.sv -----
// Shared constants and the quarter-wave sine polynomial for the mecanum wheel mixer.
`default_nettype none

package mwm_pkg;

    localparam int unsigned SINE_TABLE_BITS_DEFAULT = 10;

    // Configuration register indexes
    localparam logic REG_YAW_MIX_GAIN = 1'b0;
    localparam logic REG_SPIN_RATE    = 1'b1;

    localparam logic signed [15:0] YAW_MIX_GAIN_RESET = 16'sd256;
    localparam logic signed [15:0] SPIN_RATE_RESET    = 16'sd0;

    // Mode codes
    localparam logic [1:0] OP_DIRECT   = 2'd0;
    localparam int unsigned OP_SPIN_BIT = 1;

    // Quadrant codes of the binary angle
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Polynomial coefficients, Q15
    localparam longint SIN_A = 51472;
    localparam longint SIN_B = 21024;
    localparam longint SIN_C = 2320;

    // Quarter sine of x (Q15 fraction of a quarter turn), result 0..32768
    function automatic logic [16:0] quarter_sine(input logic [16:0] x);
        longint xv;
        longint x2;
        longint t;
        xv = longint'(x);
        x2 = (xv * xv) >>> 15;
        t  = (SIN_C * x2) >>> 15;
        t  = SIN_B - t;
        t  = (t * x2) >>> 15;
        t  = SIN_A - t;
        t  = (t * xv) >>> 15;
        return t[16:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mecanum_wheel_mixer_top.sv -----
// Top level of the mecanum wheel mixer: four-stage pipelined inverse kinematics.
`default_nettype none

// Channel   Signals                                         Direction  Flow control
// cmd       cmd_valid, cmd_stall, op, vel_x, vel_y,         in         valid / stall
//           heading, yaw_rate
// wheel     wheel_valid, wheel_stall, wheel_front_left,     out        valid / stall
//           wheel_front_right, wheel_rear_right, wheel_rear_left
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data       in         valid / ready
//
// One request enters per cycle while the output is not held.
// Each request passes through the pipeline: table lookup, products, rounding, then mix and saturate.
// Reset (rst_n, asynchronous) empties the pipeline and loads the register defaults.
// A stalled result freezes every stage; cmd_stall rises only while the output is held.
// cfg_ready is always high; a write takes effect at the next edge.

module mecanum_wheel_mixer_top
#(
    parameter int unsigned SINE_TABLE_BITS = mwm_pkg::SINE_TABLE_BITS_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire logic [1:0]         op,
    input  wire logic signed [15:0] vel_x,
    input  wire logic signed [15:0] vel_y,
    input  wire logic [15:0]        heading,
    input  wire logic signed [15:0] yaw_rate,

    output logic                    wheel_valid,
    input  wire logic               wheel_stall,
    output logic signed [15:0]      wheel_front_left,
    output logic signed [15:0]      wheel_front_right,
    output logic signed [15:0]      wheel_rear_right,
    output logic signed [15:0]      wheel_rear_left,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [15:0]        cfg_data
);

    import mwm_pkg::*;

    localparam int unsigned IDX_BITS  = SINE_TABLE_BITS - 2;
    localparam int unsigned LUT_BITS  = SINE_TABLE_BITS - 1;
    localparam int unsigned QUARTER   = 2 ** IDX_BITS;
    localparam int unsigned X_SHIFT   = 17 - SINE_TABLE_BITS;
    localparam int unsigned IDX_LOW   = 16 - SINE_TABLE_BITS;
    localparam logic [LUT_BITS-1:0] QUARTER_IDX = LUT_BITS'(QUARTER);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [15:0] yaw_mix_gain_reg;
    logic signed [15:0] spin_rate_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_mix_gain_reg <= YAW_MIX_GAIN_RESET;
            spin_rate_reg    <= SPIN_RATE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_YAW_MIX_GAIN: yaw_mix_gain_reg <= $signed(cfg_data);
                REG_SPIN_RATE:    spin_rate_reg    <= $signed(cfg_data);
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: every stage advances together unless the
    // result register holds a request the consumer has not yet taken.
    // ------------------------------------------------------------------
    logic advance;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    assign advance   = !(s4_valid_reg && wheel_stall);
    assign cmd_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= cmd_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Quarter-wave sine table, one entry per index plus the end point
    // ------------------------------------------------------------------
    logic [16:0] sine_lut [0:QUARTER];

    for (genvar g = 0; g <= QUARTER; g++)
    begin : gen_lut
        assign sine_lut[g] = quarter_sine(17'(g) << X_SHIFT);
    end

    // ------------------------------------------------------------------
    // Stage 1: look up sine and cosine, fold in the quadrant, pick yaw rate.
    // Direct mode uses the identity rotation, which returns vx and vy exactly.
    // ------------------------------------------------------------------
    logic [IDX_BITS-1:0] lut_idx;
    logic [1:0]          quad;
    logic [16:0]         qs, qc;
    logic signed [17:0]  sin_next, cos_next;
    logic signed [15:0]  wz_next;

    logic signed [17:0]  s1_sin_reg, s1_cos_reg;
    logic signed [15:0]  s1_vx_reg, s1_vy_reg, s1_wz_reg;

    assign lut_idx = heading[13:IDX_LOW];
    assign quad    = heading[15:14];
    assign qs      = sine_lut[{1'b0, lut_idx}];
    assign qc      = sine_lut[QUARTER_IDX - {1'b0, lut_idx}];

    always_comb
    begin
        sin_next = 18'sd0;
        cos_next = 18'sd32768;
        if (op != OP_DIRECT)
        begin
            unique case (quad)
                QUAD_0:
                begin
                    sin_next = $signed({1'b0, qs});
                    cos_next = $signed({1'b0, qc});
                end
                QUAD_1:
                begin
                    sin_next = $signed({1'b0, qc});
                    cos_next = -$signed({1'b0, qs});
                end
                QUAD_2:
                begin
                    sin_next = -$signed({1'b0, qs});
                    cos_next = -$signed({1'b0, qc});
                end
                default:
                begin
                    sin_next = -$signed({1'b0, qc});
                    cos_next = $signed({1'b0, qs});
                end
            endcase
        end
        wz_next = op[OP_SPIN_BIT] ? spin_rate_reg : yaw_rate;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_sin_reg <= sin_next;
            s1_cos_reg <= cos_next;
            s1_vx_reg  <= vel_x;
            s1_vy_reg  <= vel_y;
            s1_wz_reg  <= wz_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: rotation products and yaw gain product
    // ------------------------------------------------------------------
    logic signed [33:0] s2_vx_cos_reg, s2_vy_sin_reg, s2_vx_sin_reg, s2_vy_cos_reg;
    logic signed [31:0] s2_kwz_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_vx_cos_reg <= s1_vx_reg * s1_cos_reg;
            s2_vy_sin_reg <= s1_vy_reg * s1_sin_reg;
            s2_vx_sin_reg <= s1_vx_reg * s1_sin_reg;
            s2_vy_cos_reg <= s1_vy_reg * s1_cos_reg;
            s2_kwz_reg    <= yaw_mix_gain_reg * s1_wz_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: round the rotated components and the scaled yaw rate
    // ------------------------------------------------------------------
    logic signed [35:0] a_sum, b_sum;
    logic signed [32:0] kw_sum;
    logic signed [35:0] a_shift, b_shift;
    logic signed [32:0] kw_shift;

    logic signed [17:0] s3_a_reg, s3_b_reg;
    logic signed [23:0] s3_kw_reg;

    always_comb
    begin
        a_sum    = 36'(s2_vx_cos_reg) - 36'(s2_vy_sin_reg) + 36'sd16384;
        b_sum    = 36'(s2_vx_sin_reg) + 36'(s2_vy_cos_reg) + 36'sd16384;
        kw_sum   = 33'(s2_kwz_reg) + 33'sd128;
        a_shift  = a_sum >>> 15;
        b_shift  = b_sum >>> 15;
        kw_shift = kw_sum >>> 8;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_a_reg  <= a_shift[17:0];
            s3_b_reg  <= b_shift[17:0];
            s3_kw_reg <= kw_shift[23:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: mix the four wheels and saturate into the result register
    // ------------------------------------------------------------------
    function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
        logic signed [15:0] r;
        if (v > 26'sd32767)
            r = 16'sh7FFF;
        else if (v < -26'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    logic signed [25:0] a_ext, b_ext, kw_ext;
    logic signed [25:0] fl_sum, fr_sum, rr_sum, rl_sum;

    logic signed [15:0] fl_reg, fr_reg, rr_reg, rl_reg;

    always_comb
    begin
        a_ext  = 26'(s3_a_reg);
        b_ext  = 26'(s3_b_reg);
        kw_ext = 26'(s3_kw_reg);
        fl_sum = a_ext - b_ext + kw_ext;
        fr_sum = a_ext + b_ext - kw_ext;
        rr_sum = a_ext - b_ext - kw_ext;
        rl_sum = a_ext + b_ext + kw_ext;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fl_reg <= sat16(fl_sum);
            fr_reg <= sat16(fr_sum);
            rr_reg <= sat16(rr_sum);
            rl_reg <= sat16(rl_sum);
        end
    end

    assign wheel_valid       = s4_valid_reg;
    assign wheel_front_left  = fl_reg;
    assign wheel_front_right = fr_reg;
    assign wheel_rear_right  = rr_reg;
    assign wheel_rear_left   = rl_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_sin_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_sin_reg >= -18'sd32768 && s1_sin_reg <= 18'sd32768 &&
                          s1_cos_reg >= -18'sd32768 && s1_cos_reg <= 18'sd32768))
        else $error("sine or cosine out of Q15 range");

    a_direct_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_valid && op == OP_DIRECT) |=>
            (s1_sin_reg == 18'sd0 && s1_cos_reg == 18'sd32768))
        else $error("direct mode did not select the identity rotation");

    a_advance_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s3_valid_reg) |=> s4_valid_reg)
        else $error("request lost between rounding and output stages");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(s1_valid_reg) && $stable(s2_valid_reg) &&
                      $stable(s3_valid_reg)))
        else $error("pipeline moved while the output was held");

endmodule

`default_nettype wire
